[rtl/rks_pkg.sv]
// ----------------------------------------------------------------------------
// rks_pkg: shared types and constants of the keystream block unit
// Request kinds, sequencer states, the sequencer-to-datapath control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rks_pkg;

    localparam int BLOCK_BITS_DEF = 63;
    localparam int ROUNDS_DEF     = 2;

    // fixed field widths on the ports
    localparam int ACTION_W = 2;
    localparam int LAYER_W  = 2;
    localparam int ROW_W    = 6;
    localparam int WORD_W   = 63;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_ROW   = 2'd0,
        ACT_LOAD_CONST = 2'd1,
        ACT_GENERATE   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } seq_state_t;

    typedef struct packed {
        logic start;       // load key into the state
        logic data_valid;  // matrix row present on the RAM output
        logic last_row;    // that row closes its layer
        logic last_layer;  // that layer is the final affine layer
    } ctrl_t;

endpackage

`default_nettype wire

[rtl/rks_ram.sv]
// ----------------------------------------------------------------------------
// rks_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/rks_seq.sv]
// ----------------------------------------------------------------------------
// rks_seq: block generation sequencer
// Walks the matrix RAM one row per cycle over all affine layers, fetches each
// layer's constant, and tells the datapath when row data is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rks_seq #(
    parameter int BLOCK_BITS = rks_pkg::BLOCK_BITS_DEF,
    parameter int ROUNDS     = rks_pkg::ROUNDS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   start,
    input  wire logic                                   out_free,
    output logic                                        idle,
    output logic                                        out_load,
    output logic                                        mat_rd_en,
    output logic [$clog2((ROUNDS+1)*BLOCK_BITS)-1:0]    mat_rd_addr,
    output logic                                        const_rd_en,
    output logic [$clog2(ROUNDS+1)-1:0]                 const_rd_addr,
    output rks_pkg::ctrl_t                              ctrl
);

    localparam int LAYERS = ROUNDS + 1;
    localparam int MAT_AW = $clog2(LAYERS * BLOCK_BITS);
    localparam int RW     = $clog2(BLOCK_BITS);
    localparam int LW     = $clog2(LAYERS);

    rks_pkg::seq_state_t state_reg, state_next;

    logic [RW-1:0]     row_reg, row_next;
    logic [LW-1:0]     layer_reg, layer_next;
    logic [MAT_AW-1:0] addr_reg, addr_next;
    logic              dv_reg, lr_reg, ll_reg;
    logic              issue, row_end, layer_end;

    assign row_end   = (row_reg == RW'(BLOCK_BITS - 1));
    assign layer_end = (layer_reg == LW'(LAYERS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rks_pkg::ST_IDLE: begin
                if (start) state_next = rks_pkg::ST_RUN;
            end
            rks_pkg::ST_RUN: begin
                if (row_end && layer_end) state_next = rks_pkg::ST_DRAIN;
            end
            rks_pkg::ST_DRAIN: begin
                state_next = rks_pkg::ST_FIN;
            end
            rks_pkg::ST_FIN: begin
                if (out_free) state_next = rks_pkg::ST_IDLE;
            end
            default: state_next = rks_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        idle     = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            rks_pkg::ST_IDLE:  idle = 1'b1;
            rks_pkg::ST_RUN:   issue = 1'b1;
            rks_pkg::ST_DRAIN: ;
            rks_pkg::ST_FIN:   out_load = out_free;
            default: ;
        endcase
    end

    // address walk: rows of one layer, then the next layer
    always_comb begin
        row_next   = row_reg;
        layer_next = layer_reg;
        addr_next  = addr_reg;
        if (!issue) begin
            row_next   = '0;
            layer_next = '0;
            addr_next  = '0;
        end else begin
            addr_next = addr_reg + MAT_AW'(1);
            if (row_end) begin
                row_next   = '0;
                layer_next = layer_reg + LW'(1);
            end else begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rks_pkg::ST_IDLE;
            row_reg   <= '0;
            layer_reg <= '0;
            addr_reg  <= '0;
            dv_reg    <= 1'b0;
            lr_reg    <= 1'b0;
            ll_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            layer_reg <= layer_next;
            addr_reg  <= addr_next;
            dv_reg    <= issue;
            lr_reg    <= row_end;
            ll_reg    <= layer_end;
        end
    end

    assign mat_rd_en     = issue;
    assign mat_rd_addr   = addr_reg;
    // constant is fetched with row 0; it holds on the RAM output for the layer
    assign const_rd_en   = issue && (row_reg == '0);
    assign const_rd_addr = layer_reg;

    assign ctrl.start      = idle && start;
    assign ctrl.data_valid = dv_reg;
    assign ctrl.last_row   = lr_reg;
    assign ctrl.last_layer = ll_reg;

endmodule

`default_nettype wire

[rtl/rks_layer.sv]
// ----------------------------------------------------------------------------
// rks_layer: GF(2) affine layer and chi datapath
// One row parity per cycle into a shift register; at the end of each layer
// the constant is added and chi or the key feed-forward is applied.
// ----------------------------------------------------------------------------
`default_nettype none

module rks_layer #(
    parameter int BLOCK_BITS = rks_pkg::BLOCK_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rks_pkg::ctrl_t        ctrl,
    input  wire logic [BLOCK_BITS-1:0] row_data,
    input  wire logic [BLOCK_BITS-1:0] const_data,
    input  wire logic [BLOCK_BITS-1:0] key,
    output logic      [BLOCK_BITS-1:0] state
);

    logic [BLOCK_BITS-1:0] x_reg, x_next;
    logic [BLOCK_BITS-1:0] y_reg, y_full, affine, chi_out;
    logic                  par;

    assign par    = ^(row_data & x_reg);
    // row r ends up in bit r after BLOCK_BITS shifts
    assign y_full = {par, y_reg[BLOCK_BITS-1:1]};
    assign affine = y_full ^ const_data;

    for (genvar j = 0; j < BLOCK_BITS; j++) begin : g_chi
        assign chi_out[j] = affine[j] ^
            (~affine[(j + 1) % BLOCK_BITS] & affine[(j + 2) % BLOCK_BITS]);
    end

    always_comb begin
        x_next = x_reg;
        if (ctrl.start) begin
            x_next = key;
        end else if (ctrl.data_valid && ctrl.last_row) begin
            x_next = ctrl.last_layer ? (affine ^ key) : chi_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
        end else begin
            x_reg <= x_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.data_valid) begin
            y_reg <= y_full;
        end
    end

    assign state = x_reg;

endmodule

`default_nettype wire

[rtl/rasta_keystream_block_unit.sv]
// ----------------------------------------------------------------------------
// rasta_keystream_block_unit: Rasta-style keystream block generator
// Loads round matrices and constants, then produces keystream blocks.
// ----------------------------------------------------------------------------
// Usage
//   cfg_*  : key write channel; write only while the unit is idle.
//   s_axis : requests. tuser is the action (load row, load constant,
//            generate); tdata carries layer, row and row/constant bits.
//   m_axis : one keystream block per generate request.
// Load requests leave the unit idle; the row or constant is written to
// memory at the accept edge. A generate request walks the matrix memory one
// row per cycle over all ROUNDS+1 layers; the sequencer then passes through
// DRAIN and FIN, and the block is loaded into the output register: m_tvalid
// rises and s_tready returns in the same cycle. The unit takes no request in
// between; the single matrix read port sets the generate rate.
// The result sits in an output register; while the receiver stalls, load
// requests are still taken, and a following generate waits at its end until
// the register frees. Reset clears the key, the state and all handshakes;
// matrices and constants must be loaded again before generating.
// ----------------------------------------------------------------------------
`default_nettype none

module rasta_keystream_block_unit #(
    parameter int BLOCK_BITS = rks_pkg::BLOCK_BITS_DEF,
    parameter int ROUNDS     = rks_pkg::ROUNDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // key write: [62:0] key_bits
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data,
    // tuser: [1:0] action
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,
    // tdata: [1:0] round_sel, [7:2] row_sel, [70:8] row_bits
    input  wire logic [71:0] s_tdata,
    // tdata: [62:0] keystream_block
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata
);

    localparam int LAYERS   = ROUNDS + 1;
    localparam int MAT_AW   = $clog2(LAYERS * BLOCK_BITS);
    localparam int CONST_AW = $clog2(LAYERS);

    logic [rks_pkg::WORD_W-1:0]  key_reg;
    logic [rks_pkg::LAYER_W-1:0] round_sel;
    logic [rks_pkg::ROW_W-1:0]   row_sel;
    logic [rks_pkg::WORD_W-1:0]  row_bits;
    logic [63:0]                 row_ext, key_ext, state_ext;
    logic [BLOCK_BITS-1:0]       row_blk, key_blk, state;
    logic [BLOCK_BITS-1:0]       mat_rd_data, const_rd_data;
    logic [MAT_AW-1:0]           mat_wr_addr, mat_rd_addr;
    logic [CONST_AW-1:0]         const_wr_addr, const_rd_addr;
    logic                        accept, layer_ok, row_ok;
    logic                        mat_wr_en, const_wr_en, gen_start;
    logic                        mat_rd_en, const_rd_en;
    logic                        idle, out_load, out_free;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [63:0]                 m_tdata_reg;
    rks_pkg::ctrl_t              ctrl;

    assign round_sel = s_tdata[1:0];
    assign row_sel   = s_tdata[7:2];
    assign row_bits  = s_tdata[70:8];

    assign row_ext = {1'b0, row_bits};
    assign key_ext = {1'b0, key_reg};
    assign row_blk = row_ext[BLOCK_BITS-1:0];
    assign key_blk = key_ext[BLOCK_BITS-1:0];

    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign layer_ok = (int'(round_sel) <= ROUNDS);
    assign row_ok   = (int'(row_sel) < BLOCK_BITS);

    // request decode
    always_comb begin
        mat_wr_en   = 1'b0;
        const_wr_en = 1'b0;
        gen_start   = 1'b0;
        unique case (rks_pkg::action_t'(s_tuser))
            rks_pkg::ACT_LOAD_ROW:   mat_wr_en   = accept && layer_ok && row_ok;
            rks_pkg::ACT_LOAD_CONST: const_wr_en = accept && layer_ok;
            rks_pkg::ACT_GENERATE:   gen_start   = accept;
            default: ;
        endcase
    end

    assign mat_wr_addr   = MAT_AW'(int'(round_sel) * BLOCK_BITS + int'(row_sel));
    assign const_wr_addr = CONST_AW'(round_sel);

    // key register; writes are to be made only while idle (the block itself does not enforce it)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            key_reg <= cfg_data[rks_pkg::WORD_W-1:0];
        end
    end

    rks_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (LAYERS * BLOCK_BITS)
    ) u_mat_ram (
        .aclk    (aclk),
        .wr_en   (mat_wr_en),
        .wr_addr (mat_wr_addr),
        .wr_data (row_blk),
        .rd_en   (mat_rd_en),
        .rd_addr (mat_rd_addr),
        .rd_data (mat_rd_data)
    );

    rks_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (LAYERS)
    ) u_const_ram (
        .aclk    (aclk),
        .wr_en   (const_wr_en),
        .wr_addr (const_wr_addr),
        .wr_data (row_blk),
        .rd_en   (const_rd_en),
        .rd_addr (const_rd_addr),
        .rd_data (const_rd_data)
    );

    rks_seq #(
        .BLOCK_BITS (BLOCK_BITS),
        .ROUNDS     (ROUNDS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (gen_start),
        .out_free      (out_free),
        .idle          (idle),
        .out_load      (out_load),
        .mat_rd_en     (mat_rd_en),
        .mat_rd_addr   (mat_rd_addr),
        .const_rd_en   (const_rd_en),
        .const_rd_addr (const_rd_addr),
        .ctrl          (ctrl)
    );

    rks_layer #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_layer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .row_data   (mat_rd_data),
        .const_data (const_rd_data),
        .key        (key_blk),
        .state      (state)
    );

    // output register
    assign out_free  = !m_tvalid_reg || m_tready;
    assign state_ext = 64'(state);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, state_ext[rks_pkg::WORD_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[rtl/rks_checker.sv]
// ----------------------------------------------------------------------------
// rks_checker: port-level checks of the keystream block unit
// Watches request and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rks_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a generate request makes the unit busy
    a_gen_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == rks_pkg::ACT_GENERATE) |=> !s_tready)
        else $error("unit not busy after generate");

    // loads never block further requests
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tuser == rks_pkg::ACT_LOAD_ROW || s_tuser == rks_pkg::ACT_LOAD_CONST)
        |=> s_tready)
        else $error("unit busy after load");

    // a new result only follows a busy period
    a_out_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without generate work");

endmodule

bind rasta_keystream_block_unit rks_checker u_rks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/rks_stream_checker.sv]
// ----------------------------------------------------------------------------
// rks_stream_checker: scoreboard for the keystream block unit
// Watches the key write, request and result channels. It keeps its own copy of
// the key, round matrices and round constants, predicts each keystream block
// when a generate request is accepted, and compares the results in order.
// ----------------------------------------------------------------------------
module rks_stream_checker #(
    parameter int BLOCK_BITS = rks_pkg::BLOCK_BITS_DEF,
    parameter int ROUNDS     = rks_pkg::ROUNDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          mismatches,
    output int          blocks_owed,
    output int          blocks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [BLOCK_BITS-1:0] word_t;

    word_t key_reg;
    word_t row_mem [ROUNDS+1][BLOCK_BITS];
    word_t const_mem [ROUNDS+1];
    word_t blocks_due [$];

    // one affine layer: GF(2) matrix-vector product plus round constant
    function automatic word_t gf2_affine(int layer, word_t x);
        word_t y;
        y = '0;
        for (int r = 0; r < BLOCK_BITS; r++)
            y[r] = ^(row_mem[layer][r] & x);
        return y ^ const_mem[layer];
    endfunction

    function automatic word_t chi_layer(word_t x);
        word_t next1;
        word_t next2;
        next1 = {x[0], x[BLOCK_BITS-1:1]};
        next2 = {x[1:0], x[BLOCK_BITS-1:2]};
        return x ^ (~next1 & next2);
    endfunction

    function automatic word_t keystream_of(word_t k);
        word_t x;
        x = k;
        for (int rd = 0; rd < ROUNDS; rd++)
            x = chi_layer(gf2_affine(rd, x));
        return gf2_affine(ROUNDS, x) ^ k;
    endfunction

    initial begin
        mismatches     = 0;
        blocks_owed    = 0;
        blocks_checked = 0;
        key_reg        = '0;
        for (int l = 0; l <= ROUNDS; l++) begin
            const_mem[l] = '0;
            for (int r = 0; r < BLOCK_BITS; r++)
                row_mem[l][r] = '0;
        end
    end

    always @(posedge aclk) begin
        logic [1:0] layer;
        logic [5:0] row;
        word_t      bits;
        word_t      want;
        if (!aresetn) begin
            key_reg = '0;
            blocks_due.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (m_tvalid && m_tready) begin
                if (blocks_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: keystream block with none due, expected none got %h",
                             $time, m_tdata);
                end else begin
                    want = blocks_due.pop_front();
                    blocks_checked++;
                    if (m_tdata !== {1'b0, want}) begin
                        mismatches++;
                        $display("%0t: keystream mismatch, expected %h got %h",
                                 $time, {1'b0, want}, m_tdata);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                key_reg = cfg_data[BLOCK_BITS-1:0];
            if (s_tvalid && s_tready) begin
                layer = s_tdata[1:0];
                row   = s_tdata[7:2];
                bits  = s_tdata[8 +: BLOCK_BITS];
                case (rks_pkg::action_t'(s_tuser))
                    rks_pkg::ACT_LOAD_ROW: begin
                        if (layer <= ROUNDS && row < BLOCK_BITS)
                            row_mem[layer][row] = bits;
                    end
                    rks_pkg::ACT_LOAD_CONST: begin
                        if (layer <= ROUNDS)
                            const_mem[layer] = bits;
                    end
                    rks_pkg::ACT_GENERATE: begin
                        blocks_due.push_back(keystream_of(key_reg));
                    end
                    default: ;
                endcase
            end
        end
        blocks_owed = blocks_due.size();
    end

endmodule

[verif/rasta_keystream_block_unit_tb.sv]
// ----------------------------------------------------------------------------
// rasta_keystream_block_unit_tb: stimulus and verdict for the keystream unit
// Loads every round matrix row and constant, runs directed corner requests,
// then random phases under several keys with random gaps on both channels.
// ----------------------------------------------------------------------------
module rasta_keystream_block_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BITS = rks_pkg::BLOCK_BITS_DEF;
    localparam int ROUNDS     = rks_pkg::ROUNDS_DEF;
    localparam int GEN_CYCLES = (ROUNDS + 1) * BLOCK_BITS + 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_REQS = 250;
    localparam int PHASES      = 5;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] LAYER_NONE = 2'd3;
    localparam logic [5:0] ROW_NONE   = 6'd63;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    int mismatches;
    int blocks_owed;
    int blocks_checked;

    int cycle_count  = 0;
    int useful_reqs  = 0;
    int row_loads    = 0;
    int const_loads  = 0;
    int generates    = 0;
    int ignored_reqs = 0;
    int key_writes   = 0;
    bit calm         = 1'b0;

    rasta_keystream_block_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rks_stream_checker #(
        .BLOCK_BITS (BLOCK_BITS),
        .ROUNDS     (ROUNDS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tuser        (s_tuser),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .blocks_owed    (blocks_owed),
        .blocks_checked (blocks_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d blocks still due", cycle_count, blocks_owed);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly zero or short, now and then long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (calm || sel < 55)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    function automatic logic [62:0] rand_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        if (sel < 16)
            return '1;
        if (sel < 28)
            return 63'd1 << $urandom_range(0, 62);
        return 63'({$urandom, $urandom});
    endfunction

    // receiver pacing
    initial begin : rx_pace
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall    = pick_gap();
                m_tready = (stall == 0);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic push_request(input logic [1:0] act, input logic [1:0] layer,
                                input logic [5:0] row, input logic [62:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {1'b0, bits, row, layer};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (act == rks_pkg::ACT_LOAD_ROW && layer <= ROUNDS && row < BLOCK_BITS)
            row_loads++;
        else if (act == rks_pkg::ACT_LOAD_CONST && layer <= ROUNDS)
            const_loads++;
        else if (act == rks_pkg::ACT_GENERATE)
            generates++;
        else begin
            ignored_reqs++;
            return;
        end
        useful_reqs++;
    endtask

    // key changes only with nothing in flight; loads leave no result to wait on
    task automatic write_key(input logic [62:0] k);
        s_tvalid = 1'b0;
        while (blocks_owed != 0) @(negedge aclk);
        repeat (GEN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = {1'b0, k};
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        key_writes++;
    endtask

    task automatic random_request();
        int          sel;
        logic [1:0]  layer;
        logic [5:0]  row;
        sel   = $urandom_range(0, 99);
        layer = 2'($urandom_range(0, ROUNDS));
        row   = 6'($urandom_range(0, BLOCK_BITS - 1));
        if (sel < 40)
            push_request(rks_pkg::ACT_GENERATE, 2'($urandom_range(0, 3)),
                         6'($urandom_range(0, 63)), rand_word());
        else if (sel < 70)
            push_request(rks_pkg::ACT_LOAD_ROW, layer, row, rand_word());
        else if (sel < 85)
            push_request(rks_pkg::ACT_LOAD_CONST, layer, 6'($urandom_range(0, 63)),
                         rand_word());
        else if (sel < 90)
            push_request(ACT_UNUSED, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                         rand_word());
        else if (sel < 95)
            push_request(rks_pkg::ACT_LOAD_ROW, LAYER_NONE, row, rand_word());
        else if (sel < 98)
            push_request(rks_pkg::ACT_LOAD_ROW, layer, ROW_NONE, rand_word());
        else
            push_request(rks_pkg::ACT_LOAD_CONST, LAYER_NONE, row, rand_word());
    endtask

    initial begin
        int stop_at;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // fill every matrix row and constant before the first generate
        for (int l = 0; l <= ROUNDS; l++) begin
            for (int r = 0; r < BLOCK_BITS; r++)
                push_request(rks_pkg::ACT_LOAD_ROW, 2'(l), 6'(r), rand_word());
            push_request(rks_pkg::ACT_LOAD_CONST, 2'(l), '0, rand_word());
        end

        // key still at its reset value
        push_request(rks_pkg::ACT_GENERATE, '0, '0, '0);
        write_key('1);
        push_request(rks_pkg::ACT_GENERATE, LAYER_NONE, ROW_NONE, '1);
        // loads outside the layer or row range and the unused action change nothing
        push_request(rks_pkg::ACT_LOAD_ROW, LAYER_NONE, 6'd0, '1);
        push_request(rks_pkg::ACT_LOAD_ROW, 2'd0, ROW_NONE, '1);
        push_request(rks_pkg::ACT_LOAD_CONST, LAYER_NONE, ROW_NONE, '1);
        push_request(ACT_UNUSED, LAYER_NONE, ROW_NONE, '1);
        push_request(rks_pkg::ACT_GENERATE, '0, '0, '0);
        push_request(rks_pkg::ACT_LOAD_ROW, 2'(ROUNDS), 6'(BLOCK_BITS - 1), '1);
        push_request(rks_pkg::ACT_LOAD_ROW, 2'd0, 6'd0, '0);
        push_request(rks_pkg::ACT_LOAD_CONST, 2'd0, '0, '1);
        push_request(rks_pkg::ACT_LOAD_CONST, 2'(ROUNDS), '0, '0);
        push_request(rks_pkg::ACT_GENERATE, '0, '0, '0);
        write_key(63'd1 << 62);
        repeat (3) push_request(rks_pkg::ACT_GENERATE, '0, '0, rand_word());

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_key('0);
                1:       write_key('1);
                default: write_key(63'({$urandom, $urandom}));
            endcase
            calm    = (ph == 2);
            stop_at = useful_reqs + RANDOM_REQS / PHASES;
            while (useful_reqs < stop_at)
                random_request();
        end
        calm     = 1'b0;
        s_tvalid = 1'b0;

        while (blocks_owed != 0) @(negedge aclk);
        repeat (GEN_CYCLES) @(negedge aclk);

        $display("covered %0d row loads, %0d constant loads, %0d generates, %0d ignored requests",
                 row_loads, const_loads, generates, ignored_reqs);
        $display("over %0d key settings; %0d keystream blocks compared, %0d mismatches",
                 key_writes + 1, blocks_checked, mismatches);
        if (mismatches == 0 && blocks_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
